>>> rtl/core/tqwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tqwm_pkg: shared types and codes for the two-queue weighted merge
// Holds the command and result payloads, the opcode and status codes, and
// the internal command word that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package tqwm_pkg;

    localparam int FIELD_ID_W = 16;
    localparam int WEIGHT_W   = 4;
    localparam int POS_W      = 5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_POPPED  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic REG_WEIGHT_A = 1'b0;
    localparam logic REG_WEIGHT_B = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [FIELD_ID_W-1:0] customer_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [FIELD_ID_W-1:0] served_id;
        logic                  served_queue;
    } result_t;

    // Classified command as it sits in the queue between front and back.
    typedef struct packed {
        logic                  is_pop;
        logic                  to_b;
        logic [FIELD_ID_W-1:0] id;
    } op_t;

endpackage
`default_nettype wire

>>> rtl/core/tqwm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tqwm_front: command intake
// Accepts commands, masks the identifier, picks the target queue and holds
// the classified command in a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module tqwm_front #(
    parameter int ID_WIDTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  tqwm_pkg::cmd_t      cmd,
    output logic                busy,
    output logic                op_valid,
    output tqwm_pkg::op_t       op,
    input  wire                 op_take
);
    import tqwm_pkg::*;

    localparam logic [FIELD_ID_W-1:0] ID_MASK = (ID_WIDTH >= FIELD_ID_W) ? '1 :
        FIELD_ID_W'((64'd1 << ID_WIDTH) - 64'd1);

    op_t        entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push_en;
    logic       pop_en;
    op_t        new_op;

    assign busy     = (count_reg == 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign op       = entry_reg[rd_ptr_reg];
    assign push_en  = start && !busy;
    assign pop_en   = op_valid && op_take;

    always_comb
    begin
        new_op.is_pop = (cmd.opcode == OP_POP);
        new_op.id     = cmd.customer_id & ID_MASK;
        // Odd identifiers belong to queue A, even ones to queue B.
        new_op.to_b   = !new_op.id[0];
    end

    always_comb
    begin
        wr_ptr_next = push_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_en ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_en} - {1'b0, pop_en};
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            entry_reg[wr_ptr_reg] <= new_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/tqwm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tqwm_back: queue storage and weighted scheduler
// Executes one classified command per cycle: pushes write the tail of the
// selected FIFO, pops read the head chosen by the weighted round robin.
// ----------------------------------------------------------------------------
module tqwm_back #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 op_valid,
    input  tqwm_pkg::op_t       op,
    output logic                op_take,
    input  wire                 wr_en,
    input  wire                 wr_index,
    input  wire [3:0]           wr_data,
    output logic                done,
    output tqwm_pkg::result_t   result
);
    import tqwm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [FIELD_ID_W-1:0] mem_a [QUEUE_DEPTH];
    logic [FIELD_ID_W-1:0] mem_b [QUEUE_DEPTH];
    logic [FIELD_ID_W-1:0] rd_a_reg, rd_b_reg;

    logic [PW-1:0]       head_a_reg, head_a_next, tail_a_reg, tail_a_next;
    logic [PW-1:0]       head_b_reg, head_b_next, tail_b_reg, tail_b_next;
    logic [CW-1:0]       cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [WEIGHT_W-1:0] weight_a_reg, weight_b_reg;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic                queue_reg, queue_next;

    logic             we_a, we_b, re_a, re_b;
    logic             empty_a, empty_b, want_a, use_a;
    logic [POS_W-1:0] pos_inc, weight_sum;

    assign op_take = op_valid;
    assign empty_a = (cnt_a_reg == '0);
    assign empty_b = (cnt_b_reg == '0);
    assign want_a  = pos_reg < {1'b0, weight_a_reg};
    assign use_a   = want_a ? !empty_a : empty_b;
    assign pos_inc = pos_reg + POS_W'(1);
    assign weight_sum = {1'b0, weight_a_reg} + {1'b0, weight_b_reg};

    always_comb
    begin
        we_a        = 1'b0;
        we_b        = 1'b0;
        re_a        = 1'b0;
        re_b        = 1'b0;
        head_a_next = head_a_reg;
        head_b_next = head_b_reg;
        tail_a_next = tail_a_reg;
        tail_b_next = tail_b_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        pos_next    = pos_reg;
        done_next   = op_valid;
        status_next = ST_EMPTY;
        queue_next  = 1'b0;
        if (op_valid)
        begin
            if (!op.is_pop)
            begin
                queue_next = op.to_b;
                if (!op.to_b)
                begin
                    if (cnt_a_reg == FULL_CNT)
                    begin
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        status_next = ST_PUSHED;
                        we_a        = 1'b1;
                        tail_a_next = (tail_a_reg == LAST_IDX) ? '0 : tail_a_reg + PW'(1);
                        cnt_a_next  = cnt_a_reg + CW'(1);
                    end
                end
                else
                begin
                    if (cnt_b_reg == FULL_CNT)
                    begin
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        status_next = ST_PUSHED;
                        we_b        = 1'b1;
                        tail_b_next = (tail_b_reg == LAST_IDX) ? '0 : tail_b_reg + PW'(1);
                        cnt_b_next  = cnt_b_reg + CW'(1);
                    end
                end
            end
            else if (!(empty_a && empty_b))
            begin
                status_next = ST_POPPED;
                // The position wraps once it reaches the sum of both weights.
                pos_next    = (pos_inc >= weight_sum) ? '0 : pos_inc;
                if (use_a)
                begin
                    re_a        = 1'b1;
                    queue_next  = 1'b0;
                    head_a_next = (head_a_reg == LAST_IDX) ? '0 : head_a_reg + PW'(1);
                    cnt_a_next  = cnt_a_reg - CW'(1);
                end
                else
                begin
                    re_b        = 1'b1;
                    queue_next  = 1'b1;
                    head_b_next = (head_b_reg == LAST_IDX) ? '0 : head_b_reg + PW'(1);
                    cnt_b_next  = cnt_b_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[tail_a_reg] <= op.id;
        end
        if (re_a)
        begin
            rd_a_reg <= mem_a[head_a_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[tail_b_reg] <= op.id;
        end
        if (re_b)
        begin
            rd_b_reg <= mem_b[head_b_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_a_reg   <= '0;
            head_b_reg   <= '0;
            tail_a_reg   <= '0;
            tail_b_reg   <= '0;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            pos_reg      <= '0;
            weight_a_reg <= WEIGHT_W'(2);
            weight_b_reg <= WEIGHT_W'(1);
            done_reg     <= 1'b0;
            status_reg   <= ST_PUSHED;
            queue_reg    <= 1'b0;
        end
        else
        begin
            head_a_reg <= head_a_next;
            head_b_reg <= head_b_next;
            tail_a_reg <= tail_a_next;
            tail_b_reg <= tail_b_next;
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            pos_reg    <= pos_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            queue_reg  <= queue_next;
            if (wr_en && (wr_index == REG_WEIGHT_A))
            begin
                weight_a_reg <= wr_data;
            end
            if (wr_en && (wr_index == REG_WEIGHT_B))
            begin
                weight_b_reg <= wr_data;
            end
        end
    end

    assign done                = done_reg;
    assign result.status       = status_reg;
    assign result.served_queue = queue_reg;
    assign result.served_id    = (status_reg != ST_POPPED) ? '0 :
                                 (queue_reg ? rd_b_reg : rd_a_reg);

endmodule
`default_nettype wire

>>> rtl/core/two_queue_weighted_merge_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_queue_weighted_merge_core: two FIFOs merged by weighted round robin
// Pushes sort identifiers into FIFO A (odd) or B (even); pops serve them in
// weight_a:weight_b order with fallback to the non-empty FIFO.
// ----------------------------------------------------------------------------
// The block takes one command per clock while busy is low. An accepted
// command (start high, busy low) waits in the intake queue, then runs in
// the back end, whose status and FIFO RAM read are registered for done.
// The back end retires one command every cycle, so busy stays low in
// normal operation. Each result is shown for exactly one cycle and must be
// captured then. The user must write weights through wr_en, wr_index and
// wr_data only while no command is in flight; the block does not enforce it.
module two_queue_weighted_merge_core #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int ID_WIDTH    = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  tqwm_pkg::cmd_t      cmd,
    output logic                busy,
    output logic                done,
    output tqwm_pkg::result_t   result,
    input  wire                 wr_en,
    input  wire                 wr_index,
    input  wire [3:0]           wr_data
);
    import tqwm_pkg::*;

    logic op_valid;
    logic op_take;
    op_t  op;

    tqwm_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take)
    );

    tqwm_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .done     (done),
        .result   (result)
    );

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted command produced no result");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(op_valid))
        else $error("result without a command in the back end");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |->
            (result.served_id == '0 && result.served_queue == 1'b0))
        else $error("empty pop carries nonzero fields");

    a_push_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op.is_pop) |=> (result.served_queue == !$past(op.id[0])))
        else $error("push reported against the wrong queue");

endmodule
`default_nettype wire
